@@ sv/fesm_pkg.sv @@
// ----------------------------------------------------------------------------
// fesm_pkg
// Shared types and codes of the flash slot manager.
// ----------------------------------------------------------------------------
package fesm_pkg;

  localparam int SLOT_W  = 7;
  localparam int FUNC_W  = 2;
  localparam int STATE_W = 2;
  localparam int ERASE_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MOUNT  = 2'd0,
    FUNC_LOCATE = 2'd1,
    FUNC_COMMIT = 2'd2
  } func_t;

  typedef enum logic [STATE_W-1:0] {
    ST_FREE   = 2'd0,
    ST_USED   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [ERASE_W-1:0] {
    ER_NONE   = 2'd0,
    ER_FIRST  = 2'd1,
    ER_SECOND = 2'd2
  } erase_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_ERASE,
    S_MARK,
    S_RESULT
  } state_t;

endpackage

@@ sv/fesm_in_if.sv @@
// ----------------------------------------------------------------------------
// fesm_in_if
// Request channel: function code, slot index and mount status.
// ----------------------------------------------------------------------------
interface fesm_in_if;
  logic                         valid;
  logic                         ready;
  logic [fesm_pkg::FUNC_W-1:0]  func;
  logic [fesm_pkg::SLOT_W-1:0]  slot;
  logic [fesm_pkg::STATE_W-1:0] slot_state;

  modport source (output valid, func, slot, slot_state, input ready);
  modport sink   (input valid, func, slot, slot_state, output ready);
endinterface

@@ sv/fesm_out_if.sv @@
// ----------------------------------------------------------------------------
// fesm_out_if
// Response channel: read source, write target, erase block, no-free flag.
// ----------------------------------------------------------------------------
interface fesm_out_if;
  logic                         valid;
  logic                         ready;
  logic [fesm_pkg::SLOT_W-1:0]  current_slot;
  logic [fesm_pkg::SLOT_W-1:0]  target_slot;
  logic [fesm_pkg::ERASE_W-1:0] erase_half;
  logic                         none_free;

  modport source (output valid, current_slot, target_slot, erase_half, none_free,
                  input ready);
  modport sink   (input valid, current_slot, target_slot, erase_half, none_free,
                  output ready);
endinterface

@@ sv/flash_eeprom_slot_manager.sv @@
// ----------------------------------------------------------------------------
// flash_eeprom_slot_manager
// Status table of two erase blocks of flash slots with mount, locate, commit.
// ----------------------------------------------------------------------------
// Usage: req carries func, slot and slot_state; rsp returns current_slot,
// target_slot, erase_half and none_free, one response per request.
// Both channels complete a transaction when valid and ready are high.
// Reset starts a clearing pass over all 2*SLOTS_PER_BLOCK slots that marks every
// slot absent; req.ready stays low until it ends.
// Mount: a valid status is written at acceptance, then the result state.
// Locate: one full scan of the status memory, one entry per cycle through
// its single read port, then a wait state and a decide state.
// Commit: the scan, then an erase of a whole block of SLOTS_PER_BLOCK slots
// when one is needed (one write per cycle), then the target write.
// One request is in work at a time; the next one is taken after the result
// moves into the output register, while that result waits for rsp.ready.
// If rsp stalls, the block holds its finished result until the register
// frees.
// ----------------------------------------------------------------------------
module flash_eeprom_slot_manager #(
  parameter int SLOTS_PER_BLOCK = 64
) (
  input logic       clk,
  input logic       rst,
  fesm_in_if.sink   req,
  fesm_out_if.source rsp
);
  import fesm_pkg::*;

  localparam int TOTAL = 2 * SLOTS_PER_BLOCK;
  localparam int AW    = $clog2(TOTAL);
  localparam logic [AW-1:0] L_IDX = AW'(SLOTS_PER_BLOCK - 1);
  localparam logic [AW-1:0] T_IDX = AW'(TOTAL - 1);
  localparam logic [AW-1:0] N_IDX = AW'(SLOTS_PER_BLOCK);

  state_t state, state_next;

  logic [AW-1:0]      cnt;
  logic               rd_pend;
  logic [AW-1:0]      rd_idx;
  logic               found;
  logic [AW-1:0]      free_idx;
  logic               sec_absent;
  logic [FUNC_W-1:0]  func_q;
  logic               erase_sec;
  logic [AW-1:0]      wslot;

  logic               ov;
  logic [SLOT_W-1:0]  out_cur;
  logic [SLOT_W-1:0]  out_tgt;
  logic [ERASE_W-1:0] out_er;
  logic               out_nf;
  logic [SLOT_W-1:0]  res_cur;
  logic [SLOT_W-1:0]  res_tgt;
  logic [ERASE_W-1:0] res_er;
  logic               res_nf;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [STATE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [STATE_W-1:0] rdata;
  logic               accept;
  logic               load;
  logic               mount_ok;

  logic [AW-1:0]      dec_cur;
  logic [AW-1:0]      dec_w;
  erase_t             dec_er;
  logic               dec_nf;

  fesm_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept   = req.valid && req.ready;
  assign mount_ok = (req.func == FUNC_MOUNT) &&
                    (req.slot_state inside {ST_FREE, ST_USED, ST_ABSENT}) &&
                    ({{(32-SLOT_W){1'b0}}, req.slot} < 32'(TOTAL));

  // locate and commit decision from scan results
  always_comb begin
    if (!found) begin
      dec_cur = sec_absent ? L_IDX : T_IDX;
    end else if (sec_absent && (free_idx < N_IDX)) begin
      dec_cur = (free_idx == '0) ? L_IDX : free_idx - AW'(1);
    end else begin
      dec_cur = (free_idx == '0) ? T_IDX : free_idx - AW'(1);
    end
    dec_nf = 1'b0;
    if (!found || free_idx == T_IDX) begin
      dec_er = ER_FIRST;
      dec_w  = found ? T_IDX : '0;
      dec_nf = !found;
    end else if (free_idx == L_IDX) begin
      dec_er = sec_absent ? ER_FIRST : ER_SECOND;
      dec_w  = sec_absent ? '0 : L_IDX;
    end else begin
      dec_er = ER_NONE;
      dec_w  = free_idx;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (cnt == T_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_LOCATE || req.func == FUNC_COMMIT) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN:   if (cnt == T_IDX) state_next = S_WAIT;
      S_WAIT:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (func_q != FUNC_COMMIT) begin
          state_next = S_RESULT;
        end else if (dec_er != ER_NONE) begin
          state_next = S_ERASE;
        end else begin
          state_next = S_MARK;
        end
      end
      S_ERASE:  if (cnt == L_IDX) state_next = S_MARK;
      S_MARK:   state_next = S_RESULT;
      S_RESULT: if (!ov || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    waddr     = cnt;
    wdata     = ST_ABSENT;
    raddr     = cnt;
    req.ready = 1'b0;
    load      = 1'b0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        we        = req.valid && mount_ok;
        waddr     = AW'(req.slot);
        wdata     = req.slot_state;
      end
      S_ERASE: begin
        we    = 1'b1;
        waddr = erase_sec ? N_IDX + cnt : cnt;
        wdata = ST_FREE;
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = wslot;
        wdata = ST_USED;
      end
      S_RESULT: begin
        load = !ov || rsp.ready;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (state == S_CLEAR || state == S_SCAN || state == S_ERASE) begin
        cnt <= cnt + AW'(1);
      end
      if (load) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pend <= (state == S_SCAN);
    rd_idx  <= cnt;
    if (accept) begin
      func_q  <= req.func;
      found   <= 1'b0;
      res_cur <= '0;
      res_tgt <= '0;
      res_er  <= ER_NONE;
      res_nf  <= 1'b0;
    end
    if (rd_pend) begin
      if (rdata == ST_FREE && !found) begin
        found    <= 1'b1;
        free_idx <= rd_idx;
      end
      if (rd_idx == N_IDX) begin
        sec_absent <= (rdata == ST_ABSENT);
      end
    end
    if (state == S_DECIDE) begin
      res_cur   <= SLOT_W'(dec_cur);
      erase_sec <= (dec_er == ER_SECOND);
      wslot     <= dec_w;
      if (func_q == FUNC_COMMIT) begin
        res_tgt <= SLOT_W'(dec_w);
        res_er  <= dec_er;
        res_nf  <= dec_nf;
      end
    end
    if (load) begin
      out_cur <= res_cur;
      out_tgt <= res_tgt;
      out_er  <= res_er;
      out_nf  <= res_nf;
    end
  end

  assign rsp.valid        = ov;
  assign rsp.current_slot = out_cur;
  assign rsp.target_slot  = out_tgt;
  assign rsp.erase_half   = out_er;
  assign rsp.none_free    = out_nf;

  a_rise_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_RESULT)
    else $error("response appeared outside result state");

  a_none_free_erase: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.none_free |-> rsp.erase_half == ER_FIRST && rsp.target_slot == '0)
    else $error("no-free commit without first block erase");

  a_second_target: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.erase_half == ER_SECOND |-> rsp.target_slot == SLOT_W'(L_IDX))
    else $error("second block erase with wrong target");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rd_pend && state == S_IDLE)
    else $error("request taken while a scan is in flight");

endmodule

@@ sv/fesm_mem.sv @@
// ----------------------------------------------------------------------------
// fesm_mem
// Slot status memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fesm_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [fesm_pkg::STATE_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [fesm_pkg::STATE_W-1:0] rdata
);
  import fesm_pkg::*;

  logic [STATE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flash slot manager. A local copy of the slot
// table predicts each answer; mount, locate and commit requests run in
// directed cases, under a long response stall, and in random sequences
// with gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import fesm_pkg::*;

  localparam int N_BLK       = 64;
  localparam int N_SLOTS     = 2 * N_BLK;
  localparam int LAST0       = N_BLK - 1;
  localparam int LAST1       = N_SLOTS - 1;
  localparam int RAND_ITEMS  = 1780;
  localparam int HOLD_CYCLES = 600;
  localparam int WD_LIMIT    = 5000;
  localparam int TAIL_CYCLES = 3 * N_BLK + 20;

  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [STATE_W-1:0] ST_UNUSED   = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] current_slot;
    logic [SLOT_W-1:0] target_slot;
    erase_t            erase_half;
    logic              none_free;
  } slot_answer_t;

  logic clk = 1'b0;
  logic rst;

  fesm_in_if  req_if ();
  fesm_out_if rsp_if ();

  status_t      slot_tab [N_SLOTS];
  slot_answer_t answer_q [$];

  bit idle_en  = 1'b0;
  int hold_len = 0;
  int idle_cnt = 0;
  int n_fail = 0, n_work = 0, n_rsp = 0;
  int n_mount = 0, n_locate = 0, n_commit = 0;
  int n_er_first = 0, n_er_second = 0, n_none_free = 0;

  flash_eeprom_slot_manager #(.SLOTS_PER_BLOCK(N_BLK)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int first_free();
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_tab[i] == ST_FREE) return i;
    end
    return -1;
  endfunction

  function automatic logic [SLOT_W-1:0] read_source();
    int  f;
    bit  blk1_absent;
    f = first_free();
    blk1_absent = (slot_tab[N_BLK] == ST_ABSENT);
    if (f < 0) return blk1_absent ? SLOT_W'(LAST0) : SLOT_W'(LAST1);
    if (blk1_absent && f < N_BLK) return (f == 0) ? SLOT_W'(LAST0) : SLOT_W'(f - 1);
    return (f == 0) ? SLOT_W'(LAST1) : SLOT_W'(f - 1);
  endfunction

  function automatic void free_block(int base);
    for (int i = base; i < base + N_BLK; i++) slot_tab[i] = ST_FREE;
  endfunction

  function automatic slot_answer_t apply_to_table(logic [FUNC_W-1:0] fn,
                                                  logic [SLOT_W-1:0] s,
                                                  logic [STATE_W-1:0] st);
    slot_answer_t r;
    int           f;
    int           w;
    r = '0;
    case (fn)
      FUNC_MOUNT: begin
        if (st != ST_UNUSED && int'(s) < N_SLOTS) begin
          slot_tab[s] = status_t'(st);
          n_mount++;
          n_work++;
        end
      end
      FUNC_LOCATE: begin
        r.current_slot = read_source();
        n_locate++;
        n_work++;
      end
      FUNC_COMMIT: begin
        f = first_free();
        w = f;
        r.current_slot = read_source();
        if (f < 0 || f == LAST1) begin
          r.erase_half = ER_FIRST;
          free_block(0);
          if (f < 0) begin
            w = 0;
            r.none_free = 1'b1;
          end
        end else if (f == LAST0) begin
          if (slot_tab[N_BLK] == ST_ABSENT) begin
            r.erase_half = ER_FIRST;
            free_block(0);
            w = 0;
          end else begin
            r.erase_half = ER_SECOND;
            free_block(N_BLK);
            w = LAST0;
          end
        end
        slot_tab[w] = ST_USED;
        r.target_slot = SLOT_W'(w);
        n_commit++;
        n_work++;
        if (r.erase_half == ER_FIRST) n_er_first++;
        if (r.erase_half == ER_SECOND) n_er_second++;
        if (r.none_free) n_none_free++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] s,
                          input logic [STATE_W-1:0] st);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= fn;
    req_if.slot       <= s;
    req_if.slot_state <= st;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    answer_q.push_back(apply_to_table(fn, s, st));
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  // response side: random stalls, or one long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    slot_answer_t exp_a;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_rsp++;
      if (answer_q.size() == 0) begin
        $error("response with no request pending");
        n_fail++;
      end else begin
        exp_a = answer_q.pop_front();
        if (rsp_if.current_slot !== exp_a.current_slot) begin
          $error("current_slot: expected %0d, got %0d", exp_a.current_slot,
                 rsp_if.current_slot);
          n_fail++;
        end
        if (rsp_if.target_slot !== exp_a.target_slot) begin
          $error("target_slot: expected %0d, got %0d", exp_a.target_slot,
                 rsp_if.target_slot);
          n_fail++;
        end
        if (rsp_if.erase_half !== exp_a.erase_half) begin
          $error("erase_half: expected %0d, got %0d", exp_a.erase_half,
                 rsp_if.erase_half);
          n_fail++;
        end
        if (rsp_if.none_free !== exp_a.none_free) begin
          $error("none_free: expected %0d, got %0d", exp_a.none_free,
                 rsp_if.none_free);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_reset_table();
    send_req(FUNC_LOCATE, 7'd0, ST_FREE);
    send_req(FUNC_COMMIT, 7'd127, ST_UNUSED);
    send_req(FUNC_LOCATE, 7'd85, ST_USED);
  endtask

  task automatic test_ignored_items();
    send_req(FUNC_MOUNT, 7'd1, ST_UNUSED);
    send_req(FUNC_UNUSED, 7'd127, ST_UNUSED);
    send_req(FUNC_UNUSED, 7'd0, ST_FREE);
    send_req(FUNC_LOCATE, 7'd42, ST_ABSENT);
  endtask

  task automatic test_locate_wrap();
    send_req(FUNC_MOUNT, 7'(N_BLK), ST_USED);
    send_req(FUNC_MOUNT, 7'd0, ST_FREE);
    send_req(FUNC_LOCATE, 7'd0, ST_FREE);
    send_req(FUNC_MOUNT, 7'(N_BLK), ST_ABSENT);
    send_req(FUNC_LOCATE, 7'd0, ST_FREE);
    send_req(FUNC_MOUNT, 7'd127, ST_ABSENT);
  endtask

  task automatic test_commit_plain();
    send_req(FUNC_COMMIT, 7'd0, ST_FREE);
    send_req(FUNC_COMMIT, 7'd64, ST_ABSENT);
    send_req(FUNC_LOCATE, 7'd0, ST_FREE);
  endtask

  task automatic test_back_pressure();
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 3) send_req(FUNC_COMMIT, 7'($urandom), ST_FREE);
      else if (i % 2 == 1) send_req(FUNC_LOCATE, 7'($urandom), ST_FREE);
      else send_req(FUNC_MOUNT, 7'($urandom_range(N_BLK, LAST1)), ST_USED);
    end
    drain_answers();
  endtask

  task automatic test_random_mix();
    int pick;
    int n;
    int b;
    int k;
    while (n_work < RAND_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(4, 30);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) send_req(FUNC_LOCATE, 7'($urandom), 2'($urandom));
          else send_req(FUNC_COMMIT, 7'($urandom), 2'($urandom));
        end
      end else if (pick < 65) begin
        // pile used slots up to a block end so the commit can land on it
        b = $urandom_range(0, 1) ? LAST1 : LAST0;
        k = $urandom_range(1, LAST0);
        for (int i = b - k; i < b; i++) send_req(FUNC_MOUNT, 7'(i), ST_USED);
        if ($urandom_range(0, 1)) send_req(FUNC_MOUNT, 7'(b), ST_FREE);
        if ($urandom_range(0, 1))
          send_req(FUNC_MOUNT, 7'(N_BLK), 2'($urandom_range(0, 2)));
        send_req(FUNC_COMMIT, 7'($urandom), 2'($urandom));
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) send_req(FUNC_MOUNT, 7'($urandom), 2'($urandom_range(0, 2)));
        send_req(FUNC_LOCATE, 7'($urandom), 2'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_req(2'($urandom), 7'($urandom), 2'($urandom));
      end
    end
    drain_answers();
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.func        <= FUNC_MOUNT;
    req_if.slot        <= '0;
    req_if.slot_state  <= ST_FREE;
    foreach (slot_tab[i]) slot_tab[i] = ST_ABSENT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_table();
    test_ignored_items();
    test_locate_wrap();
    test_commit_plain();
    test_back_pressure();
    test_random_mix();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d table operations: %0d mounts, %0d locates, %0d commits; %0d responses.",
             n_work, n_mount, n_locate, n_commit, n_rsp);
    $display("Commits erased block one %0d times, block two %0d times, %0d with no free slot.",
             n_er_first, n_er_second, n_none_free);
    if (n_fail == 0 && answer_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fesm_pkg.sv
sv/fesm_in_if.sv
sv/fesm_out_if.sv
sv/fesm_mem.sv
sv/flash_eeprom_slot_manager.sv
verif/tb.sv
